[rtl/core/tcpft_pkg.sv]
// ----------------------------------------------------------------------------
// tcpft_pkg
// Shared constants and types for the TCP flow tracker / retransmit filter.
// ----------------------------------------------------------------------------
package tcpft_pkg;

    localparam int FLOW_SLOTS = 16;
    localparam int SLOT_W     = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;

    localparam logic [3:0] IP_VERSION_4 = 4'd4;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [31:0] KEY_PROTO   = 32'd6;

    localparam logic [2:0] V_ACCEPT = 3'd0;
    localparam logic [2:0] V_FULL   = 3'd1;
    localparam logic [2:0] V_RETX   = 3'd2;
    localparam logic [2:0] V_HELD   = 3'd3;
    localparam logic [2:0] V_ERROR  = 3'd4;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic  hit;
        logic  seq_eq;
        logic  avail;
        t_slot hit_slot;
        t_slot free_slot;
    } t_lookup;

endpackage

[rtl/core/tcpft_flow_table.sv]
// ----------------------------------------------------------------------------
// tcpft_flow_table
// Flow table with parallel key compare, lowest free slot search and update.
// ----------------------------------------------------------------------------
module tcpft_flow_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_key,
    input  logic [31:0]         i_seq,
    input  logic                i_commit,
    output tcpft_pkg::t_lookup  o_lookup
);
    import tcpft_pkg::*;

    logic [31:0]           r_key [FLOW_SLOTS];
    logic [31:0]           r_seq [FLOW_SLOTS];
    logic [FLOW_SLOTS-1:0] r_valid;

    logic [FLOW_SLOTS-1:0] match_vec;
    logic [FLOW_SLOTS-1:0] seqeq_vec;
    logic [FLOW_SLOTS-1:0] wr_new;
    logic [FLOW_SLOTS-1:0] wr_seq;
    t_lookup               lk;

    always_comb begin
        lk = '0;
        for (int i = 0; i < FLOW_SLOTS; i++) begin
            match_vec[i] = r_valid[i] && (r_key[i] == i_key);
            seqeq_vec[i] = (r_seq[i] == i_seq);
        end
        for (int i = 0; i < FLOW_SLOTS; i++) begin
            if (match_vec[i] && !lk.hit) begin
                lk.hit      = 1'b1;
                lk.hit_slot = SLOT_W'(i);
            end
            if (!r_valid[i] && !lk.avail) begin
                lk.avail     = 1'b1;
                lk.free_slot = SLOT_W'(i);
            end
        end
        lk.seq_eq = |(match_vec & seqeq_vec);
        for (int i = 0; i < FLOW_SLOTS; i++) begin
            wr_new[i] = i_commit && !lk.hit && lk.avail && (lk.free_slot == SLOT_W'(i));
            wr_seq[i] = i_commit && lk.hit && !lk.seq_eq && (lk.hit_slot == SLOT_W'(i));
        end
    end

    assign o_lookup = lk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= r_valid | wr_new;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FLOW_SLOTS; i++) begin
            if (wr_new[i]) begin
                r_key[i] <= i_key;
            end
            if (wr_new[i] || wr_seq[i]) begin
                r_seq[i] <= i_seq;
            end
        end
    end

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(wr_new | wr_seq)) else $error("more than one slot written");

    a_new_is_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        |wr_new |=> $countones(r_valid) == $countones($past(r_valid)) + 1)
        else $error("new flow did not take a free slot");

    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_valid & $past(r_valid)) == $past(r_valid)))
        else $error("flow entry lost");

endmodule

[rtl/core/tcp_flow_tracker_retransmit_filter.sv]
// ----------------------------------------------------------------------------
// tcp_flow_tracker_retransmit_filter
// Inspects PSH segments on one output device, tracks flows, drops retransmits.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   packet header fields
//  out      output     o_out_valid / i_out_stall verdict, slot, counters
//  cfg      input      i_cfg_valid / o_cfg_ready device index
//
//  A result moves from the input register into the result register once the
//  output is not stalled.
//  One transfer per cycle sustained while the output is not stalled; flow lookup is combinational, update registered.
//  Reset clears flow valid bits, counters, device index and both valid flags.
//  A stalled result holds the input register; the input stalls only then.
// ----------------------------------------------------------------------------
module tcp_flow_tracker_retransmit_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_header_present,
    input  logic [31:0] i_pkt_tag,
    input  logic [31:0] i_out_device,
    input  logic [3:0]  i_ip_version,
    input  logic [7:0]  i_ip_protocol,
    input  logic        i_push_flag,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_dest_address,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic [31:0] i_sequence_number,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result_pkt_tag,
    output logic [2:0]  o_verdict,
    output logic [3:0]  o_flow_slot,
    output logic        o_new_flow,
    output logic [31:0] o_inbound_count,
    output logic [31:0] o_tcp_count,
    output logic [31:0] o_segment_count,
    output logic [31:0] o_retransmit_drops
);
    import tcpft_pkg::*;

    logic [31:0] r_dev_idx;
    logic        r_in_valid;
    logic        r_hdr;
    logic [31:0] r_id;
    logic [31:0] r_dev;
    logic [3:0]  r_ver;
    logic [7:0]  r_proto;
    logic        r_psh;
    logic [31:0] r_sa;
    logic [31:0] r_da;
    logic [15:0] r_sp;
    logic [15:0] r_dp;
    logic [31:0] r_seq;

    logic [31:0] r_inb, r_tcp, r_segc, r_retx;
    logic [31:0] n_inb, n_tcp, n_segc, n_retx;

    logic        r_out_valid;
    logic [31:0] r_out_id;
    logic [2:0]  r_out_verdict;
    logic [3:0]  r_out_slot;
    logic        r_out_new;
    logic [31:0] r_out_inb, r_out_tcp, r_out_segc, r_out_retx;

    logic [2:0]  n_verdict;
    logic [31:0] n_id;
    logic [3:0]  n_slot;
    logic        n_new;
    logic        advance;
    logic        in_accept;
    logic        dev_ok, tcp_ok, seg;
    logic [31:0] key;
    t_lookup     lookup;
    t_slot       slot_sel;
    logic [SLOT_W+3:0] slot_ext;

    assign o_cfg_ready = 1'b1;
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign key = r_sa ^ r_da ^ {16'd0, r_sp} ^ {16'd0, r_dp} ^ KEY_PROTO;

    tcpft_flow_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (key),
        .i_seq    (r_seq),
        .i_commit (advance && seg),
        .o_lookup (lookup)
    );

    always_comb begin
        dev_ok = r_hdr && (r_dev == r_dev_idx);
        tcp_ok = dev_ok && (r_ver == IP_VERSION_4) && (r_proto == PROTO_TCP);
        seg    = tcp_ok && r_psh;
        n_inb  = r_inb + {31'd0, dev_ok};
        n_tcp  = r_tcp + {31'd0, tcp_ok};
        n_segc = r_segc + {31'd0, seg};
        n_retx = r_retx + {31'd0, seg && lookup.hit && lookup.seq_eq};
        n_id   = r_hdr ? r_id : 32'd0;
        n_new  = 1'b0;
        slot_sel = '0;
        if (!r_hdr) begin
            n_verdict = V_ERROR;
        end else if (!seg) begin
            n_verdict = V_ACCEPT;
        end else if (!lookup.hit) begin
            if (lookup.avail) begin
                n_verdict = V_HELD;
                n_new     = 1'b1;
                slot_sel  = lookup.free_slot;
            end else begin
                n_verdict = V_FULL;
            end
        end else begin
            n_verdict = lookup.seq_eq ? V_RETX : V_HELD;
            slot_sel  = lookup.hit_slot;
        end
        slot_ext = {4'd0, slot_sel};
        n_slot   = slot_ext[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_idx   <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_inb       <= '0;
            r_tcp       <= '0;
            r_segc      <= '0;
            r_retx      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_dev_idx <= i_cfg_data;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_inb       <= n_inb;
                r_tcp       <= n_tcp;
                r_segc      <= n_segc;
                r_retx      <= n_retx;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_hdr   <= i_header_present;
            r_id    <= i_pkt_tag;
            r_dev   <= i_out_device;
            r_ver   <= i_ip_version;
            r_proto <= i_ip_protocol;
            r_psh   <= i_push_flag;
            r_sa    <= i_source_address;
            r_da    <= i_dest_address;
            r_sp    <= i_source_port;
            r_dp    <= i_dest_port;
            r_seq   <= i_sequence_number;
        end
        if (advance) begin
            r_out_id      <= n_id;
            r_out_verdict <= n_verdict;
            r_out_slot    <= n_slot;
            r_out_new     <= n_new;
            r_out_inb     <= n_inb;
            r_out_tcp     <= n_tcp;
            r_out_segc    <= n_segc;
            r_out_retx    <= n_retx;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_pkt_tag   = r_out_id;
    assign o_verdict          = r_out_verdict;
    assign o_flow_slot        = r_out_slot;
    assign o_new_flow         = r_out_new;
    assign o_inbound_count    = r_out_inb;
    assign o_tcp_count        = r_out_tcp;
    assign o_segment_count    = r_out_segc;
    assign o_retransmit_drops = r_out_retx;

    a_retx_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (n_verdict == V_RETX) |=> r_retx == $past(r_retx) + 32'd1)
        else $error("retransmit drop not counted");

    a_new_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_new_flow |-> o_verdict == V_HELD)
        else $error("new flow without held verdict");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_hdr |=> r_segc == $past(r_segc) && r_inb == $past(r_inb))
        else $error("counters moved on header error");

endmodule
